// ----- hw/rtl/hapr_pkg.sv -----
// Shared types and constants for the hex-ASCII packet receiver.
package hapr_pkg;

    localparam int NUM_CHARS = 6;
    localparam int CFG_INDEX_W = 4;

    localparam logic [7:0] LEAD_RESET = 8'd58;
    localparam logic [7:0] SEGMENT_RESET = 8'd1;

    localparam logic [7:0] HEADER_END = 8'd7;
    localparam logic [7:0] TEXT_FIRST_POS = 8'd9;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_F = 8'h46;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT = 4'd1;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] segment;
    } cfg_t;

    typedef struct packed {
        logic [2:0]                 text_length;
        logic [NUM_CHARS-1:0][7:0]  chars;
    } result_t;

    // Bit 4 set marks a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] d;
        begin
            r = 5'h10;
            d = 8'd0;
            if (c inside {[ASCII_ZERO:ASCII_NINE]})
            begin
                d = c - ASCII_ZERO;
                r = {1'b0, d[3:0]};
            end
            else if (c inside {[ASCII_UPPER_A:ASCII_UPPER_F]})
            begin
                d = c - ASCII_UPPER_A + HEX_LETTER_BASE;
                r = {1'b0, d[3:0]};
            end
            else if (c inside {[ASCII_LOWER_A:ASCII_LOWER_F]})
            begin
                d = c - ASCII_LOWER_A + HEX_LETTER_BASE;
                r = {1'b0, d[3:0]};
            end
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/hapr_parser.sv -----
// Frame parser: header decode, running checksum, text capture and result build.
module hapr_parser #(
    parameter int MAX_PACKET = 32,
    parameter int DIGITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         rx_byte,
    input  hapr_pkg::cfg_t     cfg,
    output logic               push,
    output hapr_pkg::result_t  result
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PACKET);
    localparam logic [7:0] TEXT_MAX = 8'(DIGITS);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] run_reg, run_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] rsum_reg, rsum_next;
    logic [7:0] store_reg [DIGITS];

    logic [4:0] nib;
    logic [7:0] len_shift;
    logic [7:0] pos_inc;
    logic [7:0] text_idx;
    logic [7:0] text_diff;
    logic [2:0] shown_len;
    logic       store_wr;
    logic       is_lead;
    logic       in_header;

    assign nib = hapr_pkg::hex_value(rx_byte);
    assign is_lead = (rx_byte == cfg.lead);
    assign in_header = (pos_reg != 8'd0) && (pos_reg < hapr_pkg::HEADER_END);
    assign len_shift = {len_reg[3:0], nib[3:0]};
    assign pos_inc = pos_reg + 8'd1;
    assign text_idx = pos_reg - hapr_pkg::TEXT_FIRST_POS;
    assign store_wr = take && !is_lead && !in_header && (pos_reg != 8'd0)
        && (rx_byte != 8'd0) && (pos_reg >= hapr_pkg::TEXT_FIRST_POS) && (text_idx < TEXT_MAX);
    assign text_diff = len_reg - hapr_pkg::TEXT_FIRST_POS;

    always_comb
    begin
        if (len_reg <= hapr_pkg::TEXT_FIRST_POS)
        begin
            shown_len = 3'd0;
        end
        else if (text_diff > TEXT_MAX)
        begin
            shown_len = TEXT_MAX[2:0];
        end
        else
        begin
            shown_len = text_diff[2:0];
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        run_next = run_reg;
        type_next = type_reg;
        rsum_next = rsum_reg;
        push = 1'b0;
        if (take)
        begin
            if (is_lead)
            begin
                pos_next = 8'd1;
                len_next = 8'd0;
                type_next = 8'd0;
                rsum_next = 8'd0;
                run_next = rx_byte;
            end
            else if (in_header)
            begin
                if (nib[4])
                begin
                    pos_next = 8'd0;
                end
                else
                begin
                    pos_next = pos_inc;
                    if (pos_reg <= 8'd2)
                    begin
                        len_next = len_shift;
                        run_next = run_reg + rx_byte;
                        if ((pos_reg == 8'd2)
                            && ((len_shift < hapr_pkg::HEADER_END) || (len_shift > MAX_LEN)))
                        begin
                            pos_next = 8'd0;
                        end
                    end
                    else if (pos_reg <= 8'd4)
                    begin
                        type_next = {type_reg[3:0], nib[3:0]};
                        run_next = run_reg + rx_byte;
                    end
                    else
                    begin
                        rsum_next = {rsum_reg[3:0], nib[3:0]};
                    end
                end
            end
            else if (pos_reg != 8'd0)
            begin
                if (rx_byte == 8'd0)
                begin
                    pos_next = 8'd0;
                end
                else
                begin
                    if (pos_reg < len_reg)
                    begin
                        run_next = run_reg + rx_byte;
                    end
                    if (pos_inc < len_reg)
                    begin
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        pos_next = 8'd0;
                        push = (rsum_reg == run_next) && (type_reg == cfg.segment);
                    end
                end
            end
        end
    end

    always_comb
    begin
        result.text_length = shown_len;
        for (int k = 0; k < hapr_pkg::NUM_CHARS; k++)
        begin
            result.chars[k] = 8'd0;
            if ((k < DIGITS) && (3'(k) < shown_len))
            begin
                if (store_wr && (text_idx == 8'(k)))
                begin
                    result.chars[k] = rx_byte;
                end
                else
                begin
                    result.chars[k] = store_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
            len_reg <= 8'd0;
            run_reg <= 8'd0;
            type_reg <= 8'd0;
            rsum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            run_reg <= run_next;
            type_reg <= type_next;
            rsum_reg <= rsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            if (store_wr && (text_idx == 8'(k)))
            begin
                store_reg[k] <= rx_byte;
            end
        end
    end

endmodule

// ----- hw/rtl/hapr_out_buf.sv -----
// Result register with skid stage between the parser and the output channel.
module hapr_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hapr_pkg::result_t  push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output hapr_pkg::result_t  out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    hapr_pkg::result_t main_reg, main_next;
    hapr_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop = main_valid_reg && !out_stall;
    assign full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- hw/rtl/hex_ascii_packet_receiver_top.sv -----
// Top level of the hex-ASCII packet receiver.
// Input channel: one received byte per item on rx_byte, with in_valid and in_stall.
// Output channel: one item per accepted packet of the segment type, giving
// text_length and char0..char5, with out_valid and out_stall.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 lead character, 1 segment type); cfg_ready is always high.
// Throughput: one byte per cycle while in_stall is low. Each byte is parsed in the
// cycle it is accepted; a packet's result is registered in the output buffer.
// When the receiver stalls, a result waits in the output register and a second
// lands in the skid stage; in_stall rises only while that skid stage is occupied.
// Reset clears the frame state to idle, empties both result stages and loads
// lead character 58 and segment type 1.
module hex_ascii_packet_receiver_top #(
    parameter int MAX_PACKET = 32,
    parameter int DIGITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       text_length,
    output logic [7:0]                       char0,
    output logic [7:0]                       char1,
    output logic [7:0]                       char2,
    output logic [7:0]                       char3,
    output logic [7:0]                       char4,
    output logic [7:0]                       char5,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hapr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);

    hapr_pkg::cfg_t    cfg_reg;
    hapr_pkg::result_t parse_result;
    hapr_pkg::result_t out_data;
    logic              take;
    logic              push;
    logic              full;

    assign cfg_ready = 1'b1;
    assign in_stall = full;
    assign take = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead <= hapr_pkg::LEAD_RESET;
            cfg_reg.segment <= hapr_pkg::SEGMENT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == hapr_pkg::CFG_LEAD)
            begin
                cfg_reg.lead <= cfg_data;
            end
            else if (cfg_index == hapr_pkg::CFG_SEGMENT)
            begin
                cfg_reg.segment <= cfg_data;
            end
        end
    end

    hapr_parser #(
        .MAX_PACKET(MAX_PACKET),
        .DIGITS(DIGITS)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .take(take),
        .rx_byte(rx_byte),
        .cfg(cfg_reg),
        .push(push),
        .result(parse_result)
    );

    hapr_out_buf u_out_buf (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(parse_result),
        .full(full),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    assign text_length = out_data.text_length;
    assign char0 = out_data.chars[0];
    assign char1 = out_data.chars[1];
    assign char2 = out_data.chars[2];
    assign char3 = out_data.chars[3];
    assign char4 = out_data.chars[4];
    assign char5 = out_data.chars[5];

endmodule

// ----- verif/hapr_packet_checker.sv -----
// Checker for the hex-ASCII packet receiver: predicts text items and compares them.
module hapr_packet_checker #(
    parameter int MAX_PACKET = 32,
    parameter int DIGITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [7:0]                       rx_byte,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [2:0]                       text_length,
    input  logic [7:0]                       char0,
    input  logic [7:0]                       char1,
    input  logic [7:0]                       char2,
    input  logic [7:0]                       char3,
    input  logic [7:0]                       char4,
    input  logic [7:0]                       char5,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hapr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output int                               results_due,
    output int                               mismatch_count
);

    logic [7:0]        lead_char;
    logic [7:0]        display_type;
    logic [7:0]        frame_pos;
    logic [7:0]        decl_len;
    logic [7:0]        run_sum;
    logic [7:0]        type_val;
    logic [7:0]        rcv_sum;
    logic [7:0]        text_buf [hapr_pkg::NUM_CHARS];
    hapr_pkg::result_t expected_texts [$];
    int                fail_count;

    logic [hapr_pkg::NUM_CHARS-1:0][7:0] seen_chars;
    assign seen_chars = {char5, char4, char3, char2, char1, char0};

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic step_byte(input logic [7:0] c);
        int unsigned       pos;
        int unsigned       tlen;
        logic [4:0]        nib;
        hapr_pkg::result_t text_item;
        pos = frame_pos;
        if (c == lead_char)
        begin
            frame_pos = 8'd1;
            decl_len = 8'd0;
            type_val = 8'd0;
            rcv_sum = 8'd0;
            run_sum = c;
            return;
        end
        if (pos == 0)
            return;
        if (pos < hapr_pkg::HEADER_END)
        begin
            if (c >= hapr_pkg::ASCII_ZERO && c <= hapr_pkg::ASCII_NINE)
                nib = {1'b0, 4'(c - hapr_pkg::ASCII_ZERO)};
            else if (c >= hapr_pkg::ASCII_UPPER_A && c <= hapr_pkg::ASCII_UPPER_F)
                nib = {1'b0, 4'(c - hapr_pkg::ASCII_UPPER_A + hapr_pkg::HEX_LETTER_BASE)};
            else if (c >= hapr_pkg::ASCII_LOWER_A && c <= hapr_pkg::ASCII_LOWER_F)
                nib = {1'b0, 4'(c - hapr_pkg::ASCII_LOWER_A + hapr_pkg::HEX_LETTER_BASE)};
            else
                nib = 5'h10;
            if (nib[4])
            begin
                frame_pos = 8'd0;
                return;
            end
            if (pos <= 2)
            begin
                decl_len = {decl_len[3:0], nib[3:0]};
                run_sum = run_sum + c;
            end
            else if (pos <= 4)
            begin
                type_val = {type_val[3:0], nib[3:0]};
                run_sum = run_sum + c;
            end
            else
                rcv_sum = {rcv_sum[3:0], nib[3:0]};
            pos++;
            frame_pos = pos[7:0];
            if (pos == 3 && (decl_len < hapr_pkg::HEADER_END || decl_len > MAX_PACKET))
                frame_pos = 8'd0;
            return;
        end
        // drop the frame on a zero byte in the body
        if (c == 8'd0)
        begin
            frame_pos = 8'd0;
            return;
        end
        if (pos < decl_len)
            run_sum = run_sum + c;
        if (pos >= hapr_pkg::TEXT_FIRST_POS && pos - hapr_pkg::TEXT_FIRST_POS < DIGITS
            && pos - hapr_pkg::TEXT_FIRST_POS < hapr_pkg::NUM_CHARS)
            text_buf[pos - hapr_pkg::TEXT_FIRST_POS] = c;
        pos++;
        if (pos < decl_len)
        begin
            frame_pos = pos[7:0];
            return;
        end
        frame_pos = 8'd0;
        if (rcv_sum != run_sum || type_val != display_type)
            return;
        tlen = (decl_len > hapr_pkg::TEXT_FIRST_POS)
            ? 32'(decl_len - hapr_pkg::TEXT_FIRST_POS) : 0;
        if (tlen > DIGITS)
            tlen = DIGITS;
        if (tlen > hapr_pkg::NUM_CHARS)
            tlen = hapr_pkg::NUM_CHARS;
        text_item.text_length = tlen[2:0];
        for (int k = 0; k < hapr_pkg::NUM_CHARS; k++)
            text_item.chars[k] = (k < tlen) ? text_buf[k] : 8'h00;
        expected_texts.push_back(text_item);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        hapr_pkg::result_t want;
        if (!rst_n)
        begin
            lead_char = hapr_pkg::LEAD_RESET;
            display_type = hapr_pkg::SEGMENT_RESET;
            frame_pos = 8'd0;
            decl_len = 8'd0;
            run_sum = 8'd0;
            type_val = 8'd0;
            rcv_sum = 8'd0;
            for (int k = 0; k < hapr_pkg::NUM_CHARS; k++)
                text_buf[k] = 8'h00;
            expected_texts.delete();
            fail_count = 0;
            results_due <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hapr_pkg::CFG_LEAD:    lead_char = cfg_data;
                    hapr_pkg::CFG_SEGMENT: display_type = cfg_data;
                    default:               ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_texts.size() == 0)
                    report_mismatch($sformatf("text item with none expected, length %0d",
                                              text_length));
                else
                begin
                    want = expected_texts.pop_front();
                    if (text_length !== want.text_length)
                        report_mismatch($sformatf("text_length: got %0d, expected %0d",
                                                  text_length, want.text_length));
                    for (int k = 0; k < hapr_pkg::NUM_CHARS; k++)
                        if (seen_chars[k] !== want.chars[k])
                            report_mismatch($sformatf("char%0d: got %02h, expected %02h",
                                                      k, seen_chars[k], want.chars[k]));
                end
            end
            if (in_valid && !in_stall)
                step_byte(rx_byte);
            results_due <= expected_texts.size();
            mismatch_count <= fail_count;
        end
    end

endmodule

// ----- verif/hex_ascii_packet_receiver_top_tb.sv -----
// Testbench top for the hex-ASCII packet receiver: stimulus, stalls and verdict.
module hex_ascii_packet_receiver_top_tb;

    localparam int MAX_LEN = 32;
    localparam int TEXT_DIGITS = 6;
    localparam int PHASE_BYTES = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT = 3000000;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [7:0]                       rx_byte;
    logic                             out_valid;
    logic                             out_stall;
    logic [2:0]                       text_length;
    logic [7:0]                       char0;
    logic [7:0]                       char1;
    logic [7:0]                       char2;
    logic [7:0]                       char3;
    logic [7:0]                       char4;
    logic [7:0]                       char5;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [hapr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                       cfg_data;

    int         results_due;
    int         mismatch_count;
    int         burst_left;
    int         sent_bytes;
    bit         hold_request;
    logic [7:0] cur_lead;
    logic [7:0] cur_seg;
    logic [7:0] frame_bytes [$];

    hex_ascii_packet_receiver_top #(
        .MAX_PACKET(MAX_LEN),
        .DIGITS(TEXT_DIGITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .text_length(text_length),
        .char0(char0),
        .char1(char1),
        .char2(char2),
        .char3(char3),
        .char4(char4),
        .char5(char5),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    hapr_packet_checker #(
        .MAX_PACKET(MAX_LEN),
        .DIGITS(TEXT_DIGITS)
    ) packet_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .text_length(text_length),
        .char0(char0),
        .char1(char1),
        .char2(char2),
        .char3(char3),
        .char4(char4),
        .char5(char5),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .results_due(results_due),
        .mismatch_count(mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT);
        $display("hex_ascii_packet_receiver_top test failed");
        $finish;
    end

    // receiver stalls: random spans of differing density, one long hold on request
    initial
    begin : receiver_stalls
        int unsigned mode;
        int unsigned span;
        int unsigned cyc;
        bit          hold_done;
        out_stall = 1'b0;
        cyc = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    2: out_stall <= ($urandom_range(0, 7) == 0);
                    default: out_stall <= (cyc % 5 < 2);
                endcase
                cyc++;
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n < hapr_pkg::HEX_LETTER_BASE)
            ch = hapr_pkg::ASCII_ZERO + 8'(n);
        else
        begin
            ch = $urandom_range(0, 1) ? hapr_pkg::ASCII_UPPER_A : hapr_pkg::ASCII_LOWER_A;
            ch = ch + 8'(n) - hapr_pkg::HEX_LETTER_BASE;
            if (ch == cur_lead)
                ch = ch ^ (hapr_pkg::ASCII_LOWER_A - hapr_pkg::ASCII_UPPER_A);
        end
        return ch;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= hapr_pkg::ASCII_ZERO && b <= hapr_pkg::ASCII_NINE) ||
               (b >= hapr_pkg::ASCII_UPPER_A && b <= hapr_pkg::ASCII_UPPER_F) ||
               (b >= hapr_pkg::ASCII_LOWER_A && b <= hapr_pkg::ASCII_LOWER_F) ||
               b == cur_lead);
        return b;
    endfunction

    // assemble a frame; sum_err nonzero corrupts the checksum
    task automatic build_frame(input logic [7:0] len_field, input logic [7:0] typ,
                               input logic [7:0] sum_err);
        logic [7:0]  hdr [6];
        logic [7:0]  body [$];
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned nbody;
        if (len_field >= hapr_pkg::HEADER_END && len_field <= MAX_LEN)
            nbody = (len_field < hapr_pkg::HEADER_END + 8'd1)
                ? 1 : 32'(len_field - hapr_pkg::HEADER_END);
        else
            nbody = 3;
        hdr[0] = hex_char(len_field[7:4]);
        hdr[1] = hex_char(len_field[3:0]);
        hdr[2] = hex_char(typ[7:4]);
        hdr[3] = hex_char(typ[3:0]);
        sum = cur_lead + hdr[0] + hdr[1] + hdr[2] + hdr[3];
        for (int i = 0; i < nbody; i++)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == cur_lead);
            body.push_back(b);
            if (hapr_pkg::HEADER_END + i < len_field)
                sum = sum + b;
        end
        sum = sum + sum_err;
        hdr[4] = hex_char(sum[7:4]);
        hdr[5] = hex_char(sum[3:0]);
        frame_bytes = {cur_lead};
        foreach (hdr[i])
            frame_bytes.push_back(hdr[i]);
        foreach (body[i])
            frame_bytes.push_back(body[i]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent_bytes++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] lead, input logic [7:0] seg);
        cfg_valid <= 1'b1;
        cfg_index <= hapr_pkg::CFG_LEAD;
        cfg_data <= lead;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= hapr_pkg::CFG_SEGMENT;
        cfg_data <= seg;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_lead = lead;
        cur_seg = seg;
    endtask

    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned target;
        int unsigned kind;
        int unsigned n;
        logic [7:0]  len;
        logic [7:0]  typ;
        target = sent_bytes + n_bytes;
        while (sent_bytes < target)
        begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7)
                len = 8'($urandom_range(hapr_pkg::HEADER_END, 16));
            else
                len = 8'($urandom_range(17, MAX_LEN));
            typ = ($urandom_range(0, 4) != 0) ? cur_seg : 8'($urandom_range(0, 255));
            if (kind < 65)
                build_frame(len, typ, 8'd0);
            else if (kind < 72)
                build_frame(len, typ, 8'($urandom_range(1, 255)));
            else if (kind < 80)
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 6))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 1))
                    len = 8'($urandom_range(0, hapr_pkg::HEADER_END - 8'd1));
                else
                    len = 8'($urandom_range(MAX_LEN + 1, 255));
                build_frame(len, typ, 8'd0);
            end
            else if (kind < 90)
            begin
                build_frame(len, typ, 8'd0);
                frame_bytes[$urandom_range(1, hapr_pkg::HEADER_END - 8'd1)] = non_hex_byte();
            end
            else if (kind < 95)
            begin
                build_frame(len, typ, 8'd0);
                frame_bytes[$urandom_range(hapr_pkg::HEADER_END, frame_bytes.size() - 1)] = 8'h00;
            end
            else
            begin
                build_frame(len, typ, 8'd0);
                n = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > n)
                    void'(frame_bytes.pop_back());
            end
            send_frame();
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] phase_lead [5];
        logic [7:0] phase_seg [5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = hapr_pkg::CFG_LEAD;
        cfg_data = 8'h00;
        hold_request = 1'b0;
        burst_left = 0;
        sent_bytes = 0;
        cur_lead = hapr_pkg::LEAD_RESET;
        cur_seg = hapr_pkg::SEGMENT_RESET;
        phase_lead = '{8'h00, 8'hFF, hapr_pkg::LEAD_RESET, 8'h24, 8'h00};
        phase_seg = '{8'h00, 8'hFF, hapr_pkg::SEGMENT_RESET, 8'hA5, 8'h00};
        phase_lead[4] = 8'($urandom_range(0, 255));
        phase_seg[4] = 8'($urandom_range(0, 255));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignore bytes while idle
        frame_bytes = {8'h00, 8'hFF, hapr_pkg::ASCII_UPPER_A};
        send_frame();
        // length seven still swallows an extra byte
        build_frame(hapr_pkg::HEADER_END, cur_seg, 8'd0);
        send_frame();
        build_frame(hapr_pkg::TEXT_FIRST_POS, cur_seg, 8'd0);
        send_frame();
        build_frame(hapr_pkg::TEXT_FIRST_POS + 8'd1, cur_seg, 8'd0);
        send_frame();
        build_frame(hapr_pkg::TEXT_FIRST_POS + 8'(hapr_pkg::NUM_CHARS), cur_seg, 8'd0);
        send_frame();
        build_frame(8'(MAX_LEN), cur_seg, 8'd0);
        send_frame();
        build_frame(hapr_pkg::HEADER_END - 8'd1, cur_seg, 8'd0);
        send_frame();
        build_frame(8'(MAX_LEN + 1), cur_seg, 8'd0);
        send_frame();
        build_frame(8'hFF, cur_seg, 8'd0);
        send_frame();
        build_frame(8'h00, cur_seg, 8'd0);
        send_frame();
        build_frame(8'd12, cur_seg, 8'd0);
        frame_bytes[3] = non_hex_byte();
        send_frame();
        build_frame(8'd14, cur_seg, 8'd0);
        frame_bytes[10] = 8'h00;
        send_frame();
        // restart on a lead byte mid-frame
        build_frame(8'd20, cur_seg, 8'd0);
        while (frame_bytes.size() > 12)
            void'(frame_bytes.pop_back());
        send_frame();
        build_frame(8'd11, cur_seg, 8'd0);
        send_frame();
        build_frame(8'd12, cur_seg, 8'h01);
        send_frame();
        build_frame(8'd12, cur_seg ^ 8'h80, 8'd0);
        send_frame();

        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_config(phase_lead[p], phase_seg[p]);
            if (p == 2)
                hold_request = 1'b1;
            random_traffic(PHASE_BYTES);
        end

        drain();
        if (mismatch_count == 0 && results_due == 0)
            $display("hex_ascii_packet_receiver_top test passed");
        else
            $display("hex_ascii_packet_receiver_top test failed");
        $finish;
    end

endmodule
